@@ hdl/stl_pkg.sv @@
// Package for the script token lexer: token kinds, scan modes, keyword and
// punctuation tables, and the result item type.
// No dependencies; the token interface and the top level use it by scoped names.
`timescale 1ns / 1ps

package stl_pkg;

  // Default width of the character position counter.
  localparam int POS_WIDTH_DEFAULT = 16;

  // Width of the reported start offset and length.
  localparam int LEN_WIDTH = 16;

  // Depth of the result queue; an item is taken only while two entries are free.
  localparam int QUEUE_DEPTH = 4;

  // Keyword table geometry.
  localparam int KW_COUNT = 9;
  localparam int KW_SLOTS = 8;

  // Token kind codes.
  localparam logic [4:0] KIND_NUMBER  = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_KW0     = 5'd2;
  localparam logic [4:0] KIND_PLUS    = 5'd11;
  localparam logic [4:0] KIND_MINUS   = 5'd12;
  localparam logic [4:0] KIND_STAR    = 5'd13;
  localparam logic [4:0] KIND_SLASH   = 5'd14;
  localparam logic [4:0] KIND_ASSIGN  = 5'd15;
  localparam logic [4:0] KIND_LPAREN  = 5'd16;
  localparam logic [4:0] KIND_RPAREN  = 5'd17;
  localparam logic [4:0] KIND_LBRACE  = 5'd18;
  localparam logic [4:0] KIND_RBRACE  = 5'd19;
  localparam logic [4:0] KIND_LBRACK  = 5'd20;
  localparam logic [4:0] KIND_RBRACK  = 5'd21;
  localparam logic [4:0] KIND_COMMA   = 5'd22;
  localparam logic [4:0] KIND_COLON   = 5'd23;
  localparam logic [4:0] KIND_SEMI    = 5'd24;
  localparam logic [4:0] KIND_EOF     = 5'd25;
  localparam logic [4:0] KIND_UNKNOWN = 5'd26;

  // Character codes with special meaning.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Scan mode of the lexer.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2
  } mode_t;

  // One result item.
  typedef struct packed {
    logic [4:0]           token_kind;
    logic [LEN_WIDTH-1:0] token_start;
    logic [LEN_WIDTH-1:0] token_length;
    logic                 last_of_run;
  } token_t;

  // Keyword spelling, padded with NUL, and keyword lengths.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
    '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"e", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"t", "r", "u", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"f", "a", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL},
    '{"w", "h", "i", "l", "e", CH_NUL, CH_NUL, CH_NUL},
    '{"r", "e", "t", "u", "r", "n", CH_NUL, CH_NUL},
    '{"f", "u", "n", "c", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"v", "a", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"e", "c", "h", "o", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd4, 3'd3, 3'd4
  };

  // Kind of a single-character token: punctuation, or unknown otherwise.
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] kind;
    unique case (c)
      "+":     kind = KIND_PLUS;
      "-":     kind = KIND_MINUS;
      "*":     kind = KIND_STAR;
      "/":     kind = KIND_SLASH;
      "=":     kind = KIND_ASSIGN;
      "(":     kind = KIND_LPAREN;
      ")":     kind = KIND_RPAREN;
      "{":     kind = KIND_LBRACE;
      "}":     kind = KIND_RBRACE;
      "[":     kind = KIND_LBRACK;
      "]":     kind = KIND_RBRACK;
      ",":     kind = KIND_COMMA;
      ":":     kind = KIND_COLON;
      ";":     kind = KIND_SEMI;
      default: kind = KIND_UNKNOWN;
    endcase
    return kind;
  endfunction

endpackage

@@ hdl/stl_char_if.sv @@
// Input channel of the script token lexer: one source character per transfer.
// No dependencies.
`timescale 1ns / 1ps

interface stl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

@@ hdl/stl_token_if.sv @@
// Output channel of the script token lexer: one token per transfer.
// Depends on stl_pkg for the field widths.
`timescale 1ns / 1ps

interface stl_token_if;
  logic                          valid;
  logic                          ready;
  logic [4:0]                    token_kind;
  logic [stl_pkg::LEN_WIDTH-1:0] token_start;
  logic [stl_pkg::LEN_WIDTH-1:0] token_length;
  logic                          last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

@@ hdl/script_token_lexer_top.sv @@
// Top level of the script token lexer: scan state, token decode and result queue.
// Depends on stl_pkg, stl_char_if and stl_token_if.
// Latency: a token is queued in the cycle after the character that completes it
// is transferred. Throughput: one character per cycle while the four-entry result
// queue has two free entries; a character that yields two tokens fills the queue
// by one more than the drain of one token per cycle while the output is ready.
// Reset (synchronous, active high) clears the scan state, position and queue.
`timescale 1ns / 1ps

module script_token_lexer_top #(
  parameter int POS_WIDTH = stl_pkg::POS_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  stl_char_if.sink           char_in,
  stl_token_if.source        token_out
);

  localparam int PTR_WIDTH = $clog2(stl_pkg::QUEUE_DEPTH);
  localparam int CNT_WIDTH = $clog2(stl_pkg::QUEUE_DEPTH + 1);
  localparam int LW        = stl_pkg::LEN_WIDTH;
  localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

  // Scan state.
  stl_pkg::mode_t                   mode, mode_next;
  logic [POS_WIDTH-1:0]             position, position_next;
  logic [LW-1:0]                    run_start, run_start_next;
  logic [LW-1:0]                    run_length, run_length_next;
  logic [stl_pkg::KW_COUNT-1:0]     kw_flags, kw_flags_next;

  // Result queue.
  stl_pkg::token_t                  queue [stl_pkg::QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0]             wr_ptr, rd_ptr;
  logic [CNT_WIDTH-1:0]             count;

  // Decode results.
  stl_pkg::token_t                  res0, res1;
  logic [1:0]                       push_n;

  logic       take, pop;
  logic [7:0] c;
  logic       is_digit, is_alpha, is_space, is_word;
  logic       continues;
  logic [LW-1:0] pos_clamped;
  logic [31:0]   pos_ext;
  logic [4:0]    word_kind;
  logic [stl_pkg::KW_COUNT-1:0] keep_run, keep_first;

  // Keywords still matching after character ch sits at offset idx.
  function automatic logic [stl_pkg::KW_COUNT-1:0] kw_keep(
    input logic [LW-1:0] idx, input logic [7:0] ch);
    logic [stl_pkg::KW_COUNT-1:0] keep;
    for (int k = 0; k < stl_pkg::KW_COUNT; k++) begin
      keep[k] = (idx < LW'(stl_pkg::KW_LEN[k]))
                && (stl_pkg::KW_TEXT[k][idx[2:0]] == ch);
    end
    return keep;
  endfunction

  assign c    = char_in.ch;
  assign take = char_in.valid && char_in.ready;
  assign pop  = token_out.valid && token_out.ready;

  // Character classes.
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign is_space = (c == stl_pkg::CH_SPACE) || (c == stl_pkg::CH_TAB)
                    || (c == stl_pkg::CH_LF);
  assign is_word  = is_alpha || is_digit || (c == stl_pkg::CH_UNDER);

  // The character extends the open run rather than ending it.
  assign continues = ((mode == stl_pkg::MODE_NUM) && is_digit)
                     || ((mode == stl_pkg::MODE_WORD) && is_word);

  // Start offsets are reported clamped to the 16-bit field.
  assign pos_ext     = 32'(position);
  assign pos_clamped = (pos_ext > 32'(LEN_MAX)) ? LEN_MAX : pos_ext[LW-1:0];

  assign keep_run   = kw_keep(run_length, c);
  assign keep_first = kw_keep('0, c);

  // Kind of the open word: the first keyword still matching at full length.
  always_comb begin
    word_kind = stl_pkg::KIND_IDENT;
    for (int k = stl_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (kw_flags[k] && (run_length == LW'(stl_pkg::KW_LEN[k]))) begin
        word_kind = stl_pkg::KIND_KW0 + 5'(k);
      end
    end
  end

  // Next scan state.
  always_comb begin
    mode_next       = mode;
    position_next   = position;
    run_start_next  = run_start;
    run_length_next = run_length;
    kw_flags_next   = kw_flags;
    if (continues) begin
      if (mode == stl_pkg::MODE_WORD) begin
        kw_flags_next = kw_flags & keep_run;
      end
      if (run_length != LEN_MAX) begin
        run_length_next = run_length + 1'b1;
      end
      if (position != POS_MAX) begin
        position_next = position + 1'b1;
      end
    end else begin
      mode_next = stl_pkg::MODE_IDLE;
      if (position != POS_MAX) begin
        position_next = position + 1'b1;
      end
      priority if (is_space) begin
        // Whitespace only moves the position.
      end else if (is_digit) begin
        mode_next       = stl_pkg::MODE_NUM;
        run_start_next  = pos_clamped;
        run_length_next = LW'(1);
      end else if (is_alpha) begin
        mode_next       = stl_pkg::MODE_WORD;
        run_start_next  = pos_clamped;
        run_length_next = LW'(1);
        kw_flags_next   = keep_first;
      end else if (c == stl_pkg::CH_NUL) begin
        position_next = '0;
      end else begin
        // Punctuation or unknown: position advances as set above.
      end
    end
  end

  // Result tokens for this character.
  always_comb begin
    stl_pkg::token_t run_tok, single_tok;
    logic run_emit, single_emit;
    run_tok.token_kind   = (mode == stl_pkg::MODE_NUM) ? stl_pkg::KIND_NUMBER : word_kind;
    run_tok.token_start  = run_start;
    run_tok.token_length = run_length;
    run_tok.last_of_run  = 1'b0;
    run_emit = !continues && ((mode == stl_pkg::MODE_NUM) || (mode == stl_pkg::MODE_WORD));

    single_tok.token_kind   = (c == stl_pkg::CH_NUL) ? stl_pkg::KIND_EOF
                                                     : stl_pkg::punct_kind(c);
    single_tok.token_start  = pos_clamped;
    single_tok.token_length = LW'(1);
    single_tok.last_of_run  = 1'b1;
    single_emit = !continues && !is_space && !is_digit && !is_alpha;

    res0   = run_tok;
    res1   = single_tok;
    push_n = 2'd0;
    priority if (run_emit && single_emit) begin
      push_n = 2'd2;
    end else if (run_emit) begin
      res0.last_of_run = 1'b1;
      push_n = 2'd1;
    end else if (single_emit) begin
      res0   = single_tok;
      push_n = 2'd1;
    end else begin
      push_n = 2'd0;
    end
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= stl_pkg::MODE_IDLE;
      position   <= '0;
      run_start  <= '0;
      run_length <= '0;
      kw_flags   <= '1;
    end else if (take) begin
      mode       <= mode_next;
      position   <= position_next;
      run_start  <= run_start_next;
      run_length <= run_length_next;
      kw_flags   <= kw_flags_next;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (take && (push_n != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (take && (push_n == 2'd2)) begin
      queue[wr_ptr + 1'b1] <= res1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        wr_ptr <= wr_ptr + PTR_WIDTH'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (take ? CNT_WIDTH'(push_n) : '0) - CNT_WIDTH'(pop);
    end
  end

  // Ports.
  assign char_in.ready          = (count <= CNT_WIDTH'(stl_pkg::QUEUE_DEPTH - 2));
  assign token_out.valid        = (count != '0);
  assign token_out.token_kind   = queue[rd_ptr].token_kind;
  assign token_out.token_start  = queue[rd_ptr].token_start;
  assign token_out.token_length = queue[rd_ptr].token_length;
  assign token_out.last_of_run  = queue[rd_ptr].last_of_run;

  // The queue never overfills.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_WIDTH'(stl_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // End of file restarts the position.
  assert property (@(posedge clk) disable iff (rst)
    (take && (c == stl_pkg::CH_NUL)) |=> (position == '0))
    else $error("position not cleared after end of file");

  // The first of a token pair is always queued together with its partner.
  assert property (@(posedge clk) disable iff (rst)
    (token_out.valid && !token_out.last_of_run) |-> (count >= CNT_WIDTH'(2)))
    else $error("first token of a pair without its partner");

  // A character that continues a run produces nothing.
  assert property (@(posedge clk) disable iff (rst)
    (take && continues) |-> (push_n == 2'd0))
    else $error("token emitted inside a run");

  // Between tokens, a character yields at most one token.
  assert property (@(posedge clk) disable iff (rst)
    (take && (mode == stl_pkg::MODE_IDLE)) |-> (push_n != 2'd2))
    else $error("two tokens without an open run");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for script_token_lexer_top: streams source characters, predicts
// the tokens in a software model of the scanner and compares each token field by field.
// Depends on stl_pkg, stl_char_if, stl_token_if and script_token_lexer_top.
`timescale 1ns / 1ps

module tb_top;

  localparam int POS_W = stl_pkg::POS_WIDTH_DEFAULT;
  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 5;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 170;

  // Keyword kinds, in the order of the keyword table.
  localparam logic [4:0] KIND_IF     = stl_pkg::KIND_KW0;
  localparam logic [4:0] KIND_ELSE   = stl_pkg::KIND_KW0 + 5'd1;
  localparam logic [4:0] KIND_TRUE   = stl_pkg::KIND_KW0 + 5'd2;
  localparam logic [4:0] KIND_FALSE  = stl_pkg::KIND_KW0 + 5'd3;
  localparam logic [4:0] KIND_WHILE  = stl_pkg::KIND_KW0 + 5'd4;
  localparam logic [4:0] KIND_RETURN = stl_pkg::KIND_KW0 + 5'd5;
  localparam logic [4:0] KIND_FUNC   = stl_pkg::KIND_KW0 + 5'd6;
  localparam logic [4:0] KIND_VAR    = stl_pkg::KIND_KW0 + 5'd7;
  localparam logic [4:0] KIND_ECHO   = stl_pkg::KIND_KW0 + 5'd8;

  // Punctuation in kind order, starting at KIND_PLUS.
  localparam int PUNCT_COUNT = 14;
  localparam logic [8*PUNCT_COUNT-1:0] PUNCT_CHARS = "+-*/=(){}[],:;";

  logic clk = 1'b0;
  logic rst;

  stl_char_if  chars ();
  stl_token_if tokens ();

  script_token_lexer_top #(
    .POS_WIDTH(POS_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .char_in  (chars),
    .token_out(tokens)
  );

  always #CLK_HALF clk = ~clk;

  // Source text waiting to be sent, and tokens waiting to be seen.
  logic [7:0]       pending_chars [$];
  stl_pkg::token_t  expected_tokens [$];

  int unsigned char_gap_pct;
  int unsigned token_stall_pct;
  int unsigned gen_count;
  int unsigned chars_sent;
  int unsigned tokens_checked;
  int unsigned fail_count;
  int unsigned stall_cycles;

  string keyword_list [9] = '{"if", "else", "true", "false", "while", "return", "func",
                              "var", "echo"};

  // Scanner state mirrored by the predictor.
  stl_pkg::mode_t    lex_mode;
  logic [POS_W-1:0]  lex_pos;
  logic [15:0]       run_start;
  logic [15:0]       run_len;
  logic [47:0]       word_bits;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == stl_pkg::CH_SPACE || c == stl_pkg::CH_TAB || c == stl_pkg::CH_LF;
  endfunction

  // Kind of a one-character token: punctuation, or unknown for anything unlisted.
  function automatic logic [4:0] single_kind(logic [7:0] c);
    for (int i = 0; i < PUNCT_COUNT; i++) begin
      if (PUNCT_CHARS[8*(PUNCT_COUNT-1-i) +: 8] == c) begin
        return stl_pkg::KIND_PLUS + 5'(i);
      end
    end
    return stl_pkg::KIND_UNKNOWN;
  endfunction

  // A word is a keyword only when it spells one exactly; the low bytes hold the word.
  function automatic logic [4:0] word_kind(logic [15:0] len, logic [47:0] w);
    case (len)
      16'd2: begin
        if (w[15:0] == "if") return KIND_IF;
      end
      16'd3: begin
        if (w[23:0] == "var") return KIND_VAR;
      end
      16'd4: begin
        if (w[31:0] == "else") return KIND_ELSE;
        if (w[31:0] == "true") return KIND_TRUE;
        if (w[31:0] == "func") return KIND_FUNC;
        if (w[31:0] == "echo") return KIND_ECHO;
      end
      16'd5: begin
        if (w[39:0] == "false") return KIND_FALSE;
        if (w[39:0] == "while") return KIND_WHILE;
      end
      16'd6: begin
        if (w[47:0] == "return") return KIND_RETURN;
      end
      default: ;
    endcase
    return stl_pkg::KIND_IDENT;
  endfunction

  function automatic logic [15:0] clamp_offset(logic [POS_W-1:0] p);
    logic [31:0] wide;
    wide = 32'(p);
    return (wide > 32'hFFFF) ? 16'hFFFF : wide[15:0];
  endfunction

  function automatic stl_pkg::token_t make_token(logic [4:0] kind, logic [15:0] start,
                                                 logic [15:0] len);
    stl_pkg::token_t tok;
    tok.token_kind   = kind;
    tok.token_start  = start;
    tok.token_length = len;
    tok.last_of_run  = 1'b0;
    return tok;
  endfunction

  // Advance the scanner by one character and queue the tokens it completes.
  task automatic lex_char(input logic [7:0] c);
    stl_pkg::token_t made [$];
    stl_pkg::token_t tok;
    if ((lex_mode == stl_pkg::MODE_NUM && is_digit(c)) ||
        (lex_mode == stl_pkg::MODE_WORD && (is_alpha(c) || is_digit(c) ||
                                            c == stl_pkg::CH_UNDER))) begin
      if (run_len != 16'hFFFF) run_len = run_len + 16'd1;
      word_bits = {word_bits[39:0], c};
    end else begin
      // A character that cannot extend the open run closes it first.
      if (lex_mode == stl_pkg::MODE_NUM) begin
        made.push_back(make_token(stl_pkg::KIND_NUMBER, run_start, run_len));
      end else if (lex_mode == stl_pkg::MODE_WORD) begin
        made.push_back(make_token(word_kind(run_len, word_bits), run_start, run_len));
      end
      lex_mode = stl_pkg::MODE_IDLE;
      if (is_digit(c) || is_alpha(c)) begin
        lex_mode  = is_digit(c) ? stl_pkg::MODE_NUM : stl_pkg::MODE_WORD;
        run_start = clamp_offset(lex_pos);
        run_len   = 16'd1;
        word_bits = {40'd0, c};
      end else if (c == stl_pkg::CH_NUL) begin
        made.push_back(make_token(stl_pkg::KIND_EOF, clamp_offset(lex_pos), 16'd1));
      end else if (!is_space(c)) begin
        made.push_back(make_token(single_kind(c), clamp_offset(lex_pos), 16'd1));
      end
      foreach (made[i]) begin
        tok = made[i];
        tok.last_of_run = (i == made.size() - 1);
        expected_tokens.push_back(tok);
      end
    end
    // End of file restarts the offset; every other character moves it on, up to its maximum.
    if (c == stl_pkg::CH_NUL) lex_pos = '0;
    else if (lex_pos != '1) lex_pos = lex_pos + 1'b1;
  endtask

  // Character source.
  always @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      chars.ch    <= 8'd0;
    end else begin
      if (chars.valid && chars.ready) begin
        lex_char(chars.ch);
        chars_sent++;
      end
      if (!chars.valid || chars.ready) begin
        if (pending_chars.size() > 0 && $urandom_range(99) >= char_gap_pct) begin
          chars.valid <= 1'b1;
          chars.ch    <= pending_chars.pop_front();
        end else begin
          chars.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_token();
    stl_pkg::token_t want;
    if (expected_tokens.size() == 0) begin
      $error("Token with none expected: kind %0d start %0d length %0d last %0d",
             tokens.token_kind, tokens.token_start, tokens.token_length, tokens.last_of_run);
      fail_count++;
    end else begin
      want = expected_tokens.pop_front();
      if (tokens.token_kind !== want.token_kind) begin
        $error("token_kind: expected %0d, actual %0d", want.token_kind, tokens.token_kind);
        fail_count++;
      end
      if (tokens.token_start !== want.token_start) begin
        $error("token_start: expected %0d, actual %0d", want.token_start,
               tokens.token_start);
        fail_count++;
      end
      if (tokens.token_length !== want.token_length) begin
        $error("token_length: expected %0d, actual %0d", want.token_length,
               tokens.token_length);
        fail_count++;
      end
      if (tokens.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
               tokens.last_of_run);
        fail_count++;
      end
    end
    tokens_checked++;
  endtask

  // Token sink with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      tokens.ready <= 1'b0;
    end else begin
      if (tokens.valid && tokens.ready) check_token();
      tokens.ready <= ($urandom_range(99) >= token_stall_pct);
    end
  end

  // Watchdog: counts cycles without any transfer while work is outstanding.
  always @(posedge clk) begin
    if (rst || (chars.valid && chars.ready) || (tokens.valid && tokens.ready) ||
        (pending_chars.size() == 0 && expected_tokens.size() == 0 && !chars.valid)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles with work outstanding", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_char(input logic [7:0] c);
    pending_chars.push_back(c);
    gen_count++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] random_word_char();
    int unsigned r;
    r = $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return stl_pkg::CH_UNDER;
  endfunction

  function automatic logic [7:0] random_letter();
    int unsigned r;
    r = $urandom_range(51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] random_space();
    case ($urandom_range(2))
      0:       return stl_pkg::CH_SPACE;
      1:       return stl_pkg::CH_TAB;
      default: return stl_pkg::CH_LF;
    endcase
  endfunction

  // Mostly well-formed tokens with random content, plus broken words and noise.
  task automatic add_random_token();
    string word;
    int unsigned pick;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 20) begin
      push_text(keyword_list[$urandom_range(8)]);
    end else if (pick < 30) begin
      // Near misses: a keyword cut short, lengthened, or capitalized.
      word = keyword_list[$urandom_range(8)];
      case ($urandom_range(2))
        0: push_text(word.substr(0, word.len() - 2));
        1: begin
          push_text(word);
          push_char(random_word_char());
        end
        default: begin
          push_char(word[0] - 8'd32);
          push_text(word.substr(1, word.len() - 1));
        end
      endcase
    end else if (pick < 50) begin
      push_char(random_letter());
      repeat ($urandom_range(9)) push_char(random_word_char());
    end else if (pick < 65) begin
      repeat ($urandom_range(1, 7)) push_char(8'("0" + $urandom_range(9)));
    end else if (pick < 82) begin
      push_char(PUNCT_CHARS[8*$urandom_range(PUNCT_COUNT - 1) +: 8]);
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 3)) push_char(random_space());
    end else if (pick < 93) begin
      do begin
        c = 8'($urandom_range(255));
      end while (is_alpha(c) || is_digit(c) || is_space(c) || c == stl_pkg::CH_NUL ||
                 single_kind(c) != stl_pkg::KIND_UNKNOWN);
      push_char(c);
    end else if (pick < 96) begin
      push_char(stl_pkg::CH_NUL);
    end else begin
      push_char(8'($urandom_range(255)));
    end
    // Words and numbers are usually followed by a separator so they close cleanly.
    if (pick < 65 && $urandom_range(99) < 60) push_char(random_space());
  endtask

  task automatic add_random_chars(input int unsigned count);
    int unsigned goal;
    goal = gen_count + count;
    while (gen_count < goal) add_random_token();
  endtask

  task automatic wait_sent();
    while (pending_chars.size() != 0 || chars.valid) @(posedge clk);
  endtask

  initial begin
    lex_mode        = stl_pkg::MODE_IDLE;
    lex_pos         = '0;
    run_start       = 16'd0;
    run_len         = 16'd0;
    word_bits       = 48'd0;
    gen_count       = 0;
    chars_sent      = 0;
    tokens_checked  = 0;
    fail_count      = 0;
    stall_cycles    = 0;
    chars.valid     = 1'b0;
    chars.ch        = 8'd0;
    tokens.ready    = 1'b0;
    char_gap_pct    = 21;
    token_stall_pct = 83;
    rst             = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed text: keyword, mixed-case word with digit and underscore, number,
    // tab, punctuation, high bytes, a leading underscore, newline, and runs that
    // end at end of file.
    push_text("if A9_z 0123\t+");
    push_char(8'hFF);
    push_char(8'h80);
    push_char(stl_pkg::CH_UNDER);
    push_char(stl_pkg::CH_LF);
    push_text("echo");
    push_char(stl_pkg::CH_NUL);
    push_char("7");
    push_char(stl_pkg::CH_NUL);
    add_random_chars(RANDOM_PER_PHASE);
    wait_sent();

    // Receiver fast, sender slow.
    char_gap_pct    = 83;
    token_stall_pct = 21;
    add_random_chars(RANDOM_PER_PHASE);
    wait_sent();

    // Full rate on both sides, then two short programs that each end at end of file.
    char_gap_pct    = 0;
    token_stall_pct = 0;
    add_random_chars(RANDOM_PER_PHASE);
    push_char(stl_pkg::CH_NUL);
    push_text(" if 12;");
    push_char(stl_pkg::CH_NUL);
    push_text("x=1;");
    push_char(stl_pkg::CH_NUL);
    wait_sent();

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters and checked %0d tokens under three pacing mixes,",
             chars_sent, tokens_checked);
    $display("covering keywords, near misses, numbers, punctuation, stray bytes and EOF.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/stl_pkg.sv
hdl/stl_char_if.sv
hdl/stl_token_if.sv
hdl/script_token_lexer_top.sv
tb/tb_top.sv
